// ----- src/vblc_pkg.sv -----
// ----------------------------------------------------------------------------
// vblc_pkg
// Shared types, constants and the reference level table of the clusterer.
// ----------------------------------------------------------------------------
package vblc_pkg;

    localparam int SAMPLES_PER_BURST = 16;
    localparam int MAX_LEVELS        = 24;
    localparam int REFERENCE_COUNT   = 16;

    localparam int FILL_W   = $clog2(SAMPLES_PER_BURST + 1);
    localparam int SIDX_W   = $clog2(SAMPLES_PER_BURST);
    localparam int SLOT_W   = 5;
    localparam int REF_W    = 4;
    localparam logic [19:0] MEMBERS_MAX = 20'hFFFFF;

    localparam logic [2:0] ST_TURNING  = 3'd0;
    localparam logic [2:0] ST_SETTLING = 3'd1;
    localparam logic [2:0] ST_SETTLED  = 3'd2;
    localparam logic [2:0] ST_OPEN     = 3'd3;
    localparam logic [2:0] ST_GROUND   = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    localparam logic [2:0] CFG_SPREAD  = 3'd0;
    localparam logic [2:0] CFG_RUN     = 3'd1;
    localparam logic [2:0] CFG_TOL     = 3'd2;
    localparam logic [2:0] CFG_CEIL    = 3'd3;
    localparam logic [2:0] CFG_GROUND  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_EVAL,
        S_SCAN,
        S_MATCH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic insert;
        logic eval;
        logic scan_step;
        logic match_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic insert_done;
        logic burst_done;
        logic fault;
        logic need_scan;
        logic scan_done;
        logic match_done;
    } sts_t;

    function automatic logic [11:0] ref_level(input logic [REF_W-1:0] idx);
        logic [11:0] v;
        unique case (idx)
            4'd0:  v = 12'd2533;
            4'd1:  v = 12'd1308;
            4'd2:  v = 12'd1487;
            4'd3:  v = 12'd270;
            4'd4:  v = 12'd300;
            4'd5:  v = 12'd212;
            4'd6:  v = 12'd595;
            4'd7:  v = 12'd408;
            4'd8:  v = 12'd926;
            4'd9:  v = 12'd789;
            4'd10: v = 12'd2031;
            4'd11: v = 12'd1932;
            4'd12: v = 12'd3046;
            4'd13: v = 12'd2667;
            4'd14: v = 12'd2859;
            default: v = 12'd2265;
        endcase
        return v;
    endfunction

endpackage

// ----- src/vblc_ctrl.sv -----
// ----------------------------------------------------------------------------
// vblc_ctrl
// Sequencer that steps the datapath through insertion, evaluation,
// cluster scan, reference match and result hand-off.
// ----------------------------------------------------------------------------
module vblc_ctrl
    import vblc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_mode,
    output logic s_ready,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = !out_busy;
                if (s_valid && !out_busy) begin
                    if (s_mode) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.load = 1'b1;
                        state_next = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                if (sts.insert_done) begin
                    state_next = sts.burst_done ? S_EVAL : S_IDLE;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.fault) begin
                    state_next = S_OUT;
                end else begin
                    state_next = sts.need_scan ? S_SCAN : S_MATCH;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH: begin
                cmd.match_step = 1'b1;
                if (sts.match_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_busy) begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- src/vblc_dp.sv -----
// ----------------------------------------------------------------------------
// vblc_dp
// Datapath: sorted burst buffers, run tracker, cluster store with serial
// scan, reference matcher and the output register.
// ----------------------------------------------------------------------------
module vblc_dp
    import vblc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic [11:0] s_sample_mv,
    input  logic [11:0] s_sample_adc,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        out_busy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [11:0] m_median_mv,
    output logic [11:0] m_median_adc,
    output logic [11:0] m_spread_mv,
    output logic [7:0]  m_run_length,
    output logic [3:0]  m_direction_index,
    output logic signed [12:0] m_match_error_mv,
    output logic [11:0] m_match_margin_mv,
    output logic        m_level_recorded,
    output logic [4:0]  m_level_slot,
    output logic [4:0]  m_levels_held
);

    logic [11:0] spread_cfg_reg, tol_cfg_reg, ceil_cfg_reg, gnd_cfg_reg;
    logic [7:0]  run_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spread_cfg_reg <= 12'd40;
            run_cfg_reg    <= 8'd4;
            tol_cfg_reg    <= 12'd60;
            ceil_cfg_reg   <= 12'd4090;
            gnd_cfg_reg    <= 12'd5;
        end else if (cfg_we) begin
            priority case (cfg_index)
                CFG_SPREAD: spread_cfg_reg <= cfg_data;
                CFG_RUN:    run_cfg_reg    <= cfg_data[7:0];
                CFG_TOL:    tol_cfg_reg    <= cfg_data;
                CFG_CEIL:   ceil_cfg_reg   <= cfg_data;
                CFG_GROUND: gnd_cfg_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Insertion sort, one shift step per cycle from the top of the filled part.
    logic [11:0] mv_buf_reg  [SAMPLES_PER_BURST];
    logic [11:0] adc_buf_reg [SAMPLES_PER_BURST];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] mv_pos_reg, adc_pos_reg;
    logic        mv_done_reg, adc_done_reg;
    logic [11:0] new_mv_reg, new_adc_reg;

    logic [11:0] mv_left, adc_left;
    assign mv_left  = mv_buf_reg[SIDX_W'(mv_pos_reg - 1'b1)];
    assign adc_left = adc_buf_reg[SIDX_W'(adc_pos_reg - 1'b1)];

    logic mv_step_done, adc_step_done;
    assign mv_step_done  = mv_done_reg  || mv_pos_reg == '0  || mv_left <= new_mv_reg;
    assign adc_step_done = adc_done_reg || adc_pos_reg == '0 || adc_left <= new_adc_reg;

    assign sts.insert_done = mv_step_done && adc_step_done;
    assign sts.burst_done  = fill_reg == FILL_W'(SAMPLES_PER_BURST - 1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            new_mv_reg  <= s_sample_mv;
            new_adc_reg <= s_sample_adc;
            mv_pos_reg  <= fill_reg;
            adc_pos_reg <= fill_reg;
        end else if (cmd.insert) begin
            if (!mv_done_reg) begin
                if (mv_step_done) begin
                    mv_buf_reg[SIDX_W'(mv_pos_reg)] <= new_mv_reg;
                end else begin
                    mv_buf_reg[SIDX_W'(mv_pos_reg)] <= mv_left;
                    mv_pos_reg <= mv_pos_reg - 1'b1;
                end
            end
            if (!adc_done_reg) begin
                if (adc_step_done) begin
                    adc_buf_reg[SIDX_W'(adc_pos_reg)] <= new_adc_reg;
                end else begin
                    adc_buf_reg[SIDX_W'(adc_pos_reg)] <= adc_left;
                    adc_pos_reg <= adc_pos_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            mv_done_reg  <= 1'b0;
            adc_done_reg <= 1'b0;
        end else if (cmd.load) begin
            mv_done_reg  <= 1'b0;
            adc_done_reg <= 1'b0;
        end else if (cmd.insert) begin
            if (mv_step_done) begin
                mv_done_reg <= 1'b1;
            end
            if (adc_step_done) begin
                adc_done_reg <= 1'b1;
            end
            if (sts.insert_done) begin
                fill_reg <= sts.burst_done ? '0 : fill_reg + 1'b1;
            end
        end
    end

    // Burst evaluation.
    logic [11:0] med_mv, med_adc, spread;
    assign med_mv  = mv_buf_reg[SAMPLES_PER_BURST / 2];
    assign med_adc = adc_buf_reg[SAMPLES_PER_BURST / 2];
    assign spread  = mv_buf_reg[SAMPLES_PER_BURST - 1] - mv_buf_reg[0];

    logic [11:0] prev_mv_reg;
    logic        prev_valid_reg;
    logic [7:0]  run_reg;

    logic is_open, is_gnd, stable, agree;
    logic [11:0] prev_dist;
    assign is_open   = med_adc >= ceil_cfg_reg;
    assign is_gnd    = med_adc <= gnd_cfg_reg;
    assign stable    = spread <= spread_cfg_reg;
    assign prev_dist = (med_mv > prev_mv_reg) ? med_mv - prev_mv_reg : prev_mv_reg - med_mv;
    assign agree = prev_valid_reg && prev_dist <= tol_cfg_reg;

    logic [7:0] run_new;
    always_comb begin
        if (stable && agree) begin
            run_new = (run_reg == 8'd255) ? run_reg : run_reg + 1'b1;
        end else begin
            run_new = {7'd0, stable};
        end
    end
    logic settled;
    assign settled = stable && run_new >= run_cfg_reg;

    assign sts.fault     = is_open || is_gnd;
    assign sts.need_scan = settled;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            prev_mv_reg    <= '0;
            prev_valid_reg <= 1'b0;
            run_reg        <= '0;
        end else if (cmd.eval && !sts.fault) begin
            run_reg <= run_new;
            if (stable) begin
                prev_mv_reg    <= med_mv;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    // Cluster store, scanned one slot per cycle.
    logic [31:0] sum_mv_mem  [MAX_LEVELS];
    logic [31:0] sum_adc_mem [MAX_LEVELS];
    logic [19:0] members_mem [MAX_LEVELS];
    logic [SLOT_W-1:0] total_reg, scan_reg;
    logic [11:0] cur_mv_reg, cur_adc_reg, cur_spread_reg;
    logic [2:0]  cur_status_reg;
    logic        rec_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [31:0] rd_sum_mv, rd_sum_adc;
    logic [19:0] rd_members;
    logic [31:0] scaled, tol_scaled, cdist;
    logic        hit, at_end;
    assign rd_sum_mv  = sum_mv_mem[scan_reg];
    assign rd_sum_adc = sum_adc_mem[scan_reg];
    assign rd_members = members_mem[scan_reg];
    assign scaled     = 32'(cur_mv_reg * rd_members);
    assign tol_scaled = 32'(tol_cfg_reg * rd_members);
    assign cdist      = (scaled > rd_sum_mv) ? scaled - rd_sum_mv : rd_sum_mv - scaled;
    assign at_end     = scan_reg >= total_reg;
    assign hit        = !at_end && cdist <= tol_scaled;
    assign sts.scan_done = at_end || hit;

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            if (hit) begin
                if (rd_members < MEMBERS_MAX) begin
                    sum_mv_mem[scan_reg]  <= rd_sum_mv + 32'(cur_mv_reg);
                    sum_adc_mem[scan_reg] <= rd_sum_adc + 32'(cur_adc_reg);
                    members_mem[scan_reg] <= rd_members + 1'b1;
                end
            end else if (at_end && total_reg < SLOT_W'(MAX_LEVELS)) begin
                sum_mv_mem[scan_reg]  <= 32'(cur_mv_reg);
                sum_adc_mem[scan_reg] <= 32'(cur_adc_reg);
                members_mem[scan_reg] <= 20'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            total_reg <= '0;
        end else if (cmd.scan_step && at_end && !hit && total_reg < SLOT_W'(MAX_LEVELS)) begin
            total_reg <= total_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            cur_mv_reg     <= med_mv;
            cur_adc_reg    <= med_adc;
            cur_spread_reg <= spread;
            scan_reg       <= '0;
            rec_reg        <= 1'b0;
            slot_reg       <= '0;
            if (is_open) begin
                cur_status_reg <= ST_OPEN;
            end else if (is_gnd) begin
                cur_status_reg <= ST_GROUND;
            end else if (settled) begin
                cur_status_reg <= ST_SETTLED;
            end else begin
                cur_status_reg <= stable ? ST_SETTLING : ST_TURNING;
            end
        end else if (cmd.scan_step) begin
            if (hit) begin
                rec_reg  <= 1'b1;
                slot_reg <= scan_reg;
            end else if (at_end) begin
                if (total_reg < SLOT_W'(MAX_LEVELS)) begin
                    rec_reg  <= 1'b1;
                    slot_reg <= total_reg;
                end
            end else begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    // Reference match, one table entry per cycle.
    logic [REF_W:0]  ref_reg;
    logic [12:0] best_reg, second_reg;
    logic [REF_W-1:0] best_idx_reg;
    logic [11:0] ref_d;
    logic [11:0] ref_v;
    assign ref_v = ref_level(ref_reg[REF_W-1:0]);
    assign ref_d = (cur_mv_reg > ref_v) ? cur_mv_reg - ref_v : ref_v - cur_mv_reg;
    assign sts.match_done = ref_reg == (REF_W+1)'(REFERENCE_COUNT - 1);

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            ref_reg      <= '0;
            best_reg     <= 13'h1FFF;
            second_reg   <= 13'h1FFF;
            best_idx_reg <= '0;
        end else if (cmd.match_step) begin
            ref_reg <= ref_reg + 1'b1;
            if ({1'b0, ref_d} < best_reg) begin
                second_reg   <= best_reg;
                best_reg     <= {1'b0, ref_d};
                best_idx_reg <= ref_reg[REF_W-1:0];
            end else if ({1'b0, ref_d} < second_reg) begin
                second_reg <= {1'b0, ref_d};
            end
        end
    end

    logic [12:0] margin_w;
    logic [11:0] margin;
    assign margin_w = second_reg - best_reg;
    assign margin   = margin_w[12] ? 12'hFFF : margin_w[11:0];

    // Output register.
    logic m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.clear) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    logic fault_out;
    assign fault_out = cur_status_reg == ST_OPEN || cur_status_reg == ST_GROUND;

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            m_status          <= ST_CLEARED;
            m_median_mv       <= '0;
            m_median_adc      <= '0;
            m_spread_mv       <= '0;
            m_run_length      <= '0;
            m_direction_index <= '0;
            m_match_error_mv  <= '0;
            m_match_margin_mv <= '0;
            m_level_recorded  <= 1'b0;
            m_level_slot      <= '0;
            m_levels_held     <= '0;
        end else if (cmd.emit) begin
            m_status          <= cur_status_reg;
            m_median_mv       <= cur_mv_reg;
            m_median_adc      <= cur_adc_reg;
            m_spread_mv       <= cur_spread_reg;
            m_run_length      <= run_reg;
            m_levels_held     <= total_reg;
            m_direction_index <= fault_out ? '0 : best_idx_reg;
            m_match_error_mv  <= fault_out ? '0 :
                $signed({1'b0, cur_mv_reg}) - $signed({1'b0, ref_level(best_idx_reg)});
            m_match_margin_mv <= fault_out ? '0 : margin;
            m_level_recorded  <= fault_out ? 1'b0 : rec_reg;
            m_level_slot      <= fault_out ? '0 : slot_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= SLOT_W'(MAX_LEVELS))
        else $error("cluster count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_W'(SAMPLES_PER_BURST))
        else $error("burst fill out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step && hit |=> rec_reg)
        else $error("cluster hit not recorded");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_busy |=> m_valid_reg)
        else $error("result dropped while stalled");

endmodule

// ----- src/vane_burst_level_clusterer_core.sv -----
// ----------------------------------------------------------------------------
// vane_burst_level_clusterer_core
// Wind-vane burst median, stability run, level clustering and direction match.
// ----------------------------------------------------------------------------
// Input transfers on s_valid/s_ready carry one sample (s_mode low) or a clear
// request (s_mode high). Every sixteenth sample closes a burst and yields one
// result transfer on m_valid/m_ready; a clear yields one result at once.
// Each sample goes through the insertion sort that shifts one buffer entry
// per cycle. A closing sample then passes evaluation, a cluster scan when
// settled (one slot per cycle through the multiplier compare), the reference
// match and the output step; an open or ground fault skips scan and match.
// Configuration writes use cfg_we, cfg_index and cfg_data with no wait.
// Reset returns registers to defaults and clears burst fill, run state and
// the cluster count. Results sit in an output register; while the receiver
// stalls with one result pending, s_ready stays low once the block is idle.
// ----------------------------------------------------------------------------
module vane_burst_level_clusterer_core
    import vblc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [11:0] s_sample_mv,
    input  logic [11:0] s_sample_adc,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [11:0] m_median_mv,
    output logic [11:0] m_median_adc,
    output logic [11:0] m_spread_mv,
    output logic [7:0]  m_run_length,
    output logic [3:0]  m_direction_index,
    output logic signed [12:0] m_match_error_mv,
    output logic [11:0] m_match_margin_mv,
    output logic        m_level_recorded,
    output logic [4:0]  m_level_slot,
    output logic [4:0]  m_levels_held
);

    cmd_t cmd;
    sts_t sts;
    logic out_busy;

    vblc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_mode   (s_mode),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    vblc_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_sample_mv       (s_sample_mv),
        .s_sample_adc      (s_sample_adc),
        .cmd               (cmd),
        .sts               (sts),
        .out_busy          (out_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_median_mv       (m_median_mv),
        .m_median_adc      (m_median_adc),
        .m_spread_mv       (m_spread_mv),
        .m_run_length      (m_run_length),
        .m_direction_index (m_direction_index),
        .m_match_error_mv  (m_match_error_mv),
        .m_match_margin_mv (m_match_margin_mv),
        .m_level_recorded  (m_level_recorded),
        .m_level_slot      (m_level_slot),
        .m_levels_held     (m_levels_held)
    );

endmodule

// ----- test/vane_burst_level_clusterer_core_test.sv -----
// ----------------------------------------------------------------------------
// vane_burst_level_clusterer_core_test
// Drives bursts of vane samples and clear requests into the clusterer, keeps
// its own copy of the burst, run and cluster state to work out each result,
// and checks every result transfer against the oldest outstanding one.
// Several register settings are visited, among them the extreme values.
// ----------------------------------------------------------------------------
module vane_burst_level_clusterer_core_test;
    import vblc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        mode;
        logic [11:0] mv;
        logic [11:0] adc;
    } sample_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [11:0]        median_mv;
        logic [11:0]        median_adc;
        logic [11:0]        spread_mv;
        logic [7:0]         run_length;
        logic [3:0]         direction_index;
        logic signed [12:0] match_error_mv;
        logic [11:0]        match_margin_mv;
        logic               level_recorded;
        logic [4:0]         level_slot;
        logic [4:0]         levels_held;
    } burst_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_SPREAD;
    logic [11:0] cfg_data = 12'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [11:0] s_sample_mv = 12'd0;
    logic [11:0] s_sample_adc = 12'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    burst_result_t got;

    vane_burst_level_clusterer_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_sample_mv       (s_sample_mv),
        .s_sample_adc      (s_sample_adc),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (got.status),
        .m_median_mv       (got.median_mv),
        .m_median_adc      (got.median_adc),
        .m_spread_mv       (got.spread_mv),
        .m_run_length      (got.run_length),
        .m_direction_index (got.direction_index),
        .m_match_error_mv  (got.match_error_mv),
        .m_match_margin_mv (got.match_margin_mv),
        .m_level_recorded  (got.level_recorded),
        .m_level_slot      (got.level_slot),
        .m_levels_held     (got.levels_held)
    );

    localparam logic [11:0] DATASHEET_MV [16] = '{
        12'd2533, 12'd1308, 12'd1487, 12'd270, 12'd300, 12'd212, 12'd595, 12'd408,
        12'd926, 12'd789, 12'd2031, 12'd1932, 12'd3046, 12'd2667, 12'd2859, 12'd2265
    };

    sample_t       pending_samples[$];
    burst_result_t expected_results[$];
    sample_t       sample_on_bus;
    int            mismatch_count = 0;
    bit            idle_enable = 1'b1;

    // Register copies.
    int unsigned spread_limit = 40, run_required = 4, tolerance = 60;
    int unsigned ceiling = 4090, ground = 5;
    // Burst, run and cluster state.
    logic [11:0]   burst_mv[16], burst_adc[16];
    int unsigned   burst_fill = 0;
    int unsigned   prev_level = 0, run_count = 0, levels_total = 0;
    bit            prev_level_valid = 1'b0;
    longint unsigned level_sum_mv[MAX_LEVELS], level_sum_adc[MAX_LEVELS];
    longint unsigned level_members[MAX_LEVELS];

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned distance(int unsigned a, int unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic int place_level(int unsigned mv, int unsigned adc);
        longint unsigned scaled, d;
        for (int i = 0; i < levels_total; i++) begin
            scaled = longint'(mv) * level_members[i];
            d = scaled > level_sum_mv[i] ? scaled - level_sum_mv[i]
                                         : level_sum_mv[i] - scaled;
            if (d <= longint'(tolerance) * level_members[i]) begin
                if (level_members[i] < MEMBERS_MAX) begin
                    level_sum_mv[i] += mv;
                    level_sum_adc[i] += adc;
                    level_members[i]++;
                end
                return i;
            end
        end
        if (levels_total >= MAX_LEVELS) return -1;
        level_sum_mv[levels_total] = mv;
        level_sum_adc[levels_total] = adc;
        level_members[levels_total] = 1;
        levels_total++;
        return levels_total - 1;
    endfunction

    // Works out the result, if any, of one accepted input transfer.
    function automatic void predict_burst_result(sample_t s);
        burst_result_t r;
        logic [11:0] smv[16], sadc[16], t;
        int unsigned med_mv, med_adc, best, second, best_idx, d;
        bit stable, agree;
        int slot;
        r = '0;
        if (s.mode) begin
            levels_total = 0;
            prev_level_valid = 1'b0;
            prev_level = 0;
            run_count = 0;
            r.status = ST_CLEARED;
            expected_results.push_back(r);
            return;
        end
        burst_mv[burst_fill] = s.mv;
        burst_adc[burst_fill] = s.adc;
        burst_fill++;
        if (burst_fill < SAMPLES_PER_BURST) return;
        burst_fill = 0;
        smv = burst_mv;
        sadc = burst_adc;
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 15 - i; j++) begin
                if (smv[j] > smv[j+1]) begin
                    t = smv[j]; smv[j] = smv[j+1]; smv[j+1] = t;
                end
                if (sadc[j] > sadc[j+1]) begin
                    t = sadc[j]; sadc[j] = sadc[j+1]; sadc[j+1] = t;
                end
            end
        end
        med_mv = smv[8];
        med_adc = sadc[8];
        r.median_mv = 12'(med_mv);
        r.median_adc = 12'(med_adc);
        r.spread_mv = smv[15] - smv[0];
        if (med_adc >= ceiling || med_adc <= ground) begin
            r.status = med_adc >= ceiling ? ST_OPEN : ST_GROUND;
            r.run_length = 8'(run_count);
            r.levels_held = 5'(levels_total);
            expected_results.push_back(r);
            return;
        end
        stable = r.spread_mv <= spread_limit;
        agree = prev_level_valid && distance(med_mv, prev_level) <= tolerance;
        if (stable && agree) begin
            if (run_count < 255) run_count++;
        end else begin
            run_count = stable ? 1 : 0;
        end
        if (stable) begin
            prev_level = med_mv;
            prev_level_valid = 1'b1;
        end
        if (stable && run_count >= run_required) begin
            slot = place_level(med_mv, med_adc);
            if (slot >= 0) begin
                r.level_recorded = 1'b1;
                r.level_slot = 5'(slot);
            end
        end
        best = 32'hFFFF_FFFF;
        second = 32'hFFFF_FFFF;
        best_idx = 0;
        for (int i = 0; i < REFERENCE_COUNT; i++) begin
            d = distance(med_mv, DATASHEET_MV[i]);
            if (d < best) begin
                second = best;
                best = d;
                best_idx = i;
            end else if (d < second) begin
                second = d;
            end
        end
        r.direction_index = 4'(best_idx);
        r.match_error_mv = 13'(int'(med_mv) - int'(DATASHEET_MV[best_idx]));
        r.match_margin_mv = (second - best) > 4095 ? 12'hFFF : 12'(second - best);
        r.status = stable ? (run_count >= run_required ? ST_SETTLED : ST_SETTLING)
                          : ST_TURNING;
        r.run_length = 8'(run_count);
        r.levels_held = 5'(levels_total);
        expected_results.push_back(r);
    endfunction

    always @(posedge aclk) begin
        sample_t next_sample;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_burst_result(sample_on_bus);
            if (!s_valid || s_ready) begin
                if (pending_samples.size() > 0 &&
                    !(idle_enable && $urandom_range(99) < 12)) begin
                    next_sample = pending_samples.pop_front();
                    sample_on_bus = next_sample;
                    s_valid <= 1'b1;
                    s_mode <= next_sample.mode;
                    s_sample_mv <= next_sample.mv;
                    s_sample_adc <= next_sample.adc;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        burst_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %p", got);
            end else begin
                want = expected_results.pop_front();
                if (want !== got) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
        m_ready <= !(idle_enable && $urandom_range(99) < 12);
    end

    task automatic write_register(logic [2:0] idx, int unsigned value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SPREAD: spread_limit = value & 12'hFFF;
            CFG_RUN:    run_required = value & 8'hFF;
            CFG_TOL:    tolerance = value & 12'hFFF;
            CFG_CEIL:   ceiling = value & 12'hFFF;
            CFG_GROUND: ground = value & 12'hFFF;
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned sp, int unsigned rn, int unsigned tl,
                             int unsigned ce, int unsigned gr);
        write_register(CFG_SPREAD, sp);
        write_register(CFG_RUN, rn);
        write_register(CFG_TOL, tl);
        write_register(CFG_CEIL, ce);
        write_register(CFG_GROUND, gr);
    endtask

    task automatic push_sample(logic mode, int mv, int adc);
        sample_t s;
        s.mode = mode;
        s.mv = 12'(mv < 0 ? 0 : (mv > 3300 ? 3300 : mv));
        s.adc = 12'(adc < 0 ? 0 : (adc > 4095 ? 4095 : adc));
        pending_samples.push_back(s);
    endtask

    // A burst around one level; rail_adc >= 0 pins every ADC count there.
    task automatic push_burst(int level, int jitter, int rail_adc);
        int mv;
        for (int i = 0; i < SAMPLES_PER_BURST; i++) begin
            mv = level + $urandom_range(2 * jitter) - jitter;
            if (rail_adc >= 0)
                push_sample(1'b0, mv, rail_adc);
            else
                push_sample(1'b0, mv, mv * 4095 / 3300 + $urandom_range(6) - 3);
        end
    endtask

    task automatic wait_until_idle();
        while (pending_samples.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic random_traffic(int unsigned bursts);
        int unsigned pick, level, repeats;
        int unsigned done = 0;
        while (done < bursts) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                level = $urandom_range(3300);
                repeats = $urandom_range(8, 1);
                for (int k = 0; k < repeats; k++)
                    push_burst(level, $urandom_range(25), -1);
                done += repeats;
            end else if (pick < 82) begin
                push_burst($urandom_range(3300), $urandom_range(1650), -1);
                done++;
            end else if (pick < 88) begin
                push_burst($urandom_range(3300), 10,
                           $urandom_range(1) ? $urandom_range(4095, 4000)
                                             : $urandom_range(20));
                done++;
            end else if (pick < 92) begin
                repeat ($urandom_range(15)) push_sample(1'b0, $urandom_range(3300),
                                                        $urandom_range(4095));
                push_sample(1'b1, $urandom_range(3300), $urandom_range(4095));
            end else begin
                for (int k = 0; k < SAMPLES_PER_BURST; k++)
                    push_sample(1'b0, $urandom_range(3300), $urandom_range(4095));
                done++;
            end
        end
        wait_until_idle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: rails, a clear in mid-burst, a settled run midway between two reference levels.
        push_burst(3300, 0, 4095);
        push_burst(0, 0, 0);
        repeat (5) push_sample(1'b0, 1500, 1861);
        push_sample(1'b1, 3300, 4095);
        repeat (11) push_sample(1'b0, 1500, 1861);
        repeat (5) push_burst(285, 3, -1);
        push_burst(1650, 1650, -1);
        wait_until_idle();

        random_traffic(30);

        idle_enable = 1'b0;
        configure(4095, 1, 0, 4095, 0);
        random_traffic(25);
        idle_enable = 1'b1;

        configure(0, 255, 4095, 4000, 100);
        random_traffic(10);

        configure(100, 0, 4095, 0, 4095);
        push_burst(1000, 5, -1);
        wait_until_idle();
        write_register(CFG_CEIL, 4095);
        random_traffic(15);

        configure(300, 2, 150, 4095, 4095);
        push_burst(2000, 5, -1);
        wait_until_idle();
        write_register(CFG_GROUND, 0);
        random_traffic(25);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
